FILE: rtl/hjsg_pkg.sv
package hjsg_pkg;

    // Field and register widths
    localparam int FRAME_W  = 64;
    localparam int SLOT_W   = 6;
    localparam int TAB_W    = 18;
    localparam int TAB_DEPTH = 64;
    localparam int OFF_W    = 16;
    localparam int NDC_W    = 33;
    localparam int PHASE_W  = 7;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    // Shared divider: 64-bit dividend shift register, 16-bit divisor
    localparam int DVD_W    = 64;
    localparam int DIV_W    = 16;
    localparam int DIV_BITS = 4;
    localparam int CNT_W    = 5;

    // Passes per operation: dividend bits / DIV_BITS
    localparam logic [CNT_W-1:0] MOD_PASSES = CNT_W'(64 / DIV_BITS);
    localparam logic [CNT_W-1:0] NDC_PASSES = CNT_W'(36 / DIV_BITS);

    // Base-3 scale: floor(N * 65536 / 81) == (N * ceil(2^32 / 81)) >> 16 for N below 81
    localparam int H3_PROD_W = 32;
    localparam logic [H3_PROD_W-1:0] BASE3_RECIP = 32'd53024288;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT    = 2'd3;

    // Request codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FRAME_ZERO  = 2'd1,
        ST_ZERO_DIM    = 2'd2,
        ST_TABLE_RANGE = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MOD  = 8'b0000_0010,
        S_LOOK = 8'b0000_0100,
        S_SEL  = 8'b0000_1000,
        S_H3   = 8'b0001_0000,
        S_NDCX = 8'b0010_0000,
        S_NDCY = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

endpackage

FILE: rtl/hjsg_ram.sv
module hjsg_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/halton_jitter_sample_generator.sv
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_we               cfg_index, cfg_data
// in       in         in_valid / in_stall  func, frame_number, table_slot, table_x, table_y
// out      out        out_valid / out_stall phase, offset_x, offset_y, ndc_x, ndc_y, status
//
// A load request writes the table and leaves the block idle. A sample request holds
// in_stall high after its accept until its result is handed to the output register;
// a frame-zero request goes straight to that hand-over. The shared restoring divider (4 quotient bits a cycle)
// makes 16 passes for the frame modulo, 9 for each NDC axis; base-3 scale is one multiply.
// The result sits in an output register; a new request is taken while it waits.
// Reset clears control and configuration; the offset table is not cleared.
module halton_jitter_sample_generator
    import hjsg_pkg::*;
#(
    parameter int MAX_PHASES = 64,
    parameter int MAX_FB_DIM = 16384
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [FRAME_W-1:0]         frame_number,
    input  logic [SLOT_W-1:0]          table_slot,
    input  logic signed [TAB_W-1:0]    table_x,
    input  logic signed [TAB_W-1:0]    table_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [PHASE_W-1:0]         phase,
    output logic signed [OFF_W-1:0]    offset_x,
    output logic signed [OFF_W-1:0]    offset_y,
    output logic signed [NDC_W-1:0]    ndc_x,
    output logic signed [NDC_W-1:0]    ndc_y,
    output logic [1:0]                 status
);

    localparam logic [PHASE_W-1:0] PC_MAX  = PHASE_W'(MAX_PHASES);
    localparam logic [DIV_W-1:0]   DIM_MAX = DIV_W'(MAX_FB_DIM);

    // Base-3 digit reversal of the 4 low digits (input below 81)
    function automatic logic [PHASE_W-1:0] tern_rev4(input logic [PHASE_W-1:0] p);
        logic [PHASE_W-1:0] v;
        logic [1:0]         d0;
        logic [1:0]         d1;
        logic [1:0]         d2;
        logic [1:0]         d3;
        v = p;
        if (v >= 7'd54)
        begin
            d3 = 2'd2;
            v  = v - 7'd54;
        end
        else if (v >= 7'd27)
        begin
            d3 = 2'd1;
            v  = v - 7'd27;
        end
        else
        begin
            d3 = 2'd0;
        end
        if (v >= 7'd18)
        begin
            d2 = 2'd2;
            v  = v - 7'd18;
        end
        else if (v >= 7'd9)
        begin
            d2 = 2'd1;
            v  = v - 7'd9;
        end
        else
        begin
            d2 = 2'd0;
        end
        if (v >= 7'd6)
        begin
            d1 = 2'd2;
            v  = v - 7'd6;
        end
        else if (v >= 7'd3)
        begin
            d1 = 2'd1;
            v  = v - 7'd3;
        end
        else
        begin
            d1 = 2'd0;
        end
        d0 = v[1:0];
        return ({5'd0, d0} * 7'd27) + ({5'd0, d1} * 7'd9) + ({5'd0, d2} * 7'd3)
               + {5'd0, d3};
    endfunction

    // Left-aligned |off| * 2^17 in a 36-bit dividend field
    function automatic logic [DVD_W-1:0] ndc_dividend(input logic signed [TAB_W-1:0] off);
        logic [TAB_W-1:0] mag;
        mag = off[TAB_W-1] ? TAB_W'(~$unsigned(off) + 18'd1) : $unsigned(off);
        return {3'b000, mag[15:0], 17'd0, 28'd0};
    endfunction

    // Apply the sign back onto a truncated quotient
    function automatic logic [NDC_W-1:0] ndc_result(input logic [DVD_W-1:0] q,
                                                    input logic neg);
        logic [NDC_W-1:0] q33;
        q33 = q[NDC_W-1:0];
        return neg ? NDC_W'(~q33 + 33'd1) : q33;
    endfunction

    // Configuration registers
    logic               mode_reg,   mode_next;
    logic [PHASE_W-1:0] pcount_reg, pcount_next;
    logic [CFG_W-1:0]   fbw_reg,    fbw_next;
    logic [CFG_W-1:0]   fbh_reg,    fbh_next;

    // Sequencer and shared divider
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [DVD_W-1:0]   dvd_reg,   dvd_next;
    logic [DIV_W-1:0]   rem_reg,   rem_next;
    logic [DIV_W-1:0]   dsr_reg,   dsr_next;
    logic [DVD_W-1:0]   div_dvd;
    logic [DIV_W-1:0]   div_rem;

    // Per-request working values
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic signed [TAB_W-1:0] ox_reg,   ox_next;
    logic signed [TAB_W-1:0] oy_reg,   oy_next;
    logic [NDC_W-1:0]       ndcx_reg,  ndcx_next;
    logic [NDC_W-1:0]       ndcy_reg,  ndcy_next;
    status_t                stat_reg,  stat_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [PHASE_W-1:0]     out_phase_reg, out_phase_next;
    logic [OFF_W-1:0]       out_ox_reg,    out_ox_next;
    logic [OFF_W-1:0]       out_oy_reg,    out_oy_next;
    logic [NDC_W-1:0]       out_ndcx_reg,  out_ndcx_next;
    logic [NDC_W-1:0]       out_ndcy_reg,  out_ndcy_next;
    status_t                out_stat_reg,  out_stat_next;

    // Offset table
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [2*TAB_W-1:0]     ram_rdata;
    logic signed [TAB_W-1:0] tab_x;
    logic signed [TAB_W-1:0] tab_y;

    // Effective configuration
    logic [PHASE_W-1:0]     pc_eff;
    logic [DIV_W-1:0]       w_eff;
    logic [DIV_W-1:0]       h_eff;
    logic [PHASE_W-1:0]     rev2;
    logic [OFF_W-1:0]       h2_off;
    logic [H3_PROD_W-1:0]   h3_prod;
    logic [OFF_W-1:0]       h3_off;
    logic                   in_take;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    assign pc_eff = (pcount_reg == '0) ? PHASE_W'(1)
                  : ((pcount_reg > PC_MAX) ? PC_MAX : pcount_reg);
    assign w_eff  = ({1'b0, fbw_reg} > DIM_MAX) ? DIM_MAX : {1'b0, fbw_reg};
    assign h_eff  = ({1'b0, fbh_reg} > DIM_MAX) ? DIM_MAX : {1'b0, fbh_reg};

    // Halton base 2: bit-reversed phase times 512, minus one half
    always_comb
    begin
        for (int i = 0; i < PHASE_W; i++)
        begin
            rev2[i] = phase_reg[PHASE_W-1-i];
        end
    end
    assign h2_off = {~rev2[6], rev2[5:0], 9'd0};
    // Halton base 3: reversed digits held in the dividend register, scaled by 65536/81
    assign h3_prod = {{(H3_PROD_W-PHASE_W){1'b0}}, dvd_reg[PHASE_W-1:0]} * BASE3_RECIP;
    assign h3_off  = {~h3_prod[31], h3_prod[30:16]};

    // Offset table memory, x in the upper half
    assign ram_we    = in_take && (func == FUNC_LOAD);
    assign ram_raddr = SLOT_W'(phase_reg - PHASE_W'(1));
    assign tab_x     = ram_rdata[2*TAB_W-1:TAB_W];
    assign tab_y     = ram_rdata[TAB_W-1:0];

    hjsg_ram #(
        .WIDTH(2 * TAB_W),
        .DEPTH(TAB_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (table_slot),
        .wdata ({table_x, table_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared restoring divider: DIV_BITS quotient bits per pass
    always_comb
    begin
        logic [DIV_W:0] t;
        logic           ge;
        div_rem = rem_reg;
        div_dvd = dvd_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t  = {div_rem, div_dvd[DVD_W-1]};
            ge = (t >= {1'b0, dsr_reg});
            if (ge)
            begin
                t = t - {1'b0, dsr_reg};
            end
            div_rem = t[DIV_W-1:0];
            div_dvd = {div_dvd[DVD_W-2:0], ge};
        end
    end

    // Configuration writes
    always_comb
    begin
        mode_next   = mode_reg;
        pcount_next = pcount_reg;
        fbw_next    = fbw_reg;
        fbh_next    = fbh_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_MODE: mode_next   = cfg_data[0];
                CFG_PHASE_COUNT:  pcount_next = cfg_data[PHASE_W-1:0];
                CFG_FB_WIDTH:     fbw_next    = cfg_data;
                CFG_FB_HEIGHT:    fbh_next    = cfg_data;
                default:          mode_next   = mode_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        phase_next     = phase_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ndcx_next      = ndcx_reg;
        ndcy_next      = ndcy_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_phase_next = out_phase_reg;
        out_ox_next    = out_ox_reg;
        out_oy_next    = out_oy_reg;
        out_ndcx_next  = out_ndcx_reg;
        out_ndcy_next  = out_ndcy_reg;
        out_stat_next  = out_stat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (func == FUNC_SAMPLE))
                begin
                    if (frame_number == '0)
                    begin
                        phase_next = '0;
                        stat_next  = ST_FRAME_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dvd_next   = frame_number - 64'd1;
                        rem_next   = '0;
                        dsr_next   = {9'd0, pc_eff};
                        cnt_next   = MOD_PASSES - CNT_W'(1);
                        state_next = S_MOD;
                    end
                end
            end

            // (frame - 1) mod phase_count
            S_MOD:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    phase_next = div_rem[PHASE_W-1:0] + PHASE_W'(1);
                    state_next = S_LOOK;
                end
            end

            // Table read in flight; dimension check
            S_LOOK:
            begin
                if ((w_eff == '0) || (h_eff == '0))
                begin
                    stat_next  = ST_ZERO_DIM;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SEL;
                end
            end

            S_SEL:
            begin
                if (mode_reg)
                begin
                    ox_next = tab_x;
                    oy_next = tab_y;
                    if ((tab_x[17:15] != 3'b000 && tab_x[17:15] != 3'b111)
                        || (tab_y[17:15] != 3'b000 && tab_y[17:15] != 3'b111))
                    begin
                        stat_next  = ST_TABLE_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dvd_next   = ndc_dividend(tab_x);
                        rem_next   = '0;
                        dsr_next   = w_eff;
                        cnt_next   = NDC_PASSES - CNT_W'(1);
                        state_next = S_NDCX;
                    end
                end
                else
                begin
                    ox_next    = {{2{h2_off[15]}}, h2_off};
                    dvd_next   = {{(DVD_W-PHASE_W){1'b0}}, tern_rev4(phase_reg)};
                    state_next = S_H3;
                end
            end

            // floor(N * 65536 / 81), then start the x axis
            S_H3:
            begin
                oy_next    = {{2{h3_off[15]}}, h3_off};
                dvd_next   = ndc_dividend(ox_reg);
                rem_next   = '0;
                dsr_next   = w_eff;
                cnt_next   = NDC_PASSES - CNT_W'(1);
                state_next = S_NDCX;
            end

            S_NDCX:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    ndcx_next  = ndc_result(div_dvd, ox_reg[TAB_W-1]);
                    dvd_next   = ndc_dividend(oy_reg);
                    rem_next   = '0;
                    dsr_next   = h_eff;
                    cnt_next   = NDC_PASSES - CNT_W'(1);
                    state_next = S_NDCY;
                end
            end

            S_NDCY:
            begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    ndcy_next  = ndc_result(div_dvd, oy_reg[TAB_W-1]);
                    stat_next  = ST_OK;
                    state_next = S_DONE;
                end
            end

            // Hand over to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_phase_next = phase_reg;
                    out_stat_next  = stat_reg;
                    if (stat_reg == ST_OK)
                    begin
                        out_ox_next   = ox_reg[OFF_W-1:0];
                        out_oy_next   = oy_reg[OFF_W-1:0];
                        out_ndcx_next = ndcx_reg;
                        out_ndcy_next = ndcy_reg;
                    end
                    else
                    begin
                        out_ox_next   = '0;
                        out_oy_next   = '0;
                        out_ndcx_next = '0;
                        out_ndcy_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            pcount_reg    <= PHASE_W'(8);
            fbw_reg       <= CFG_W'(1920);
            fbh_reg       <= CFG_W'(1080);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            pcount_reg    <= pcount_next;
            fbw_reg       <= fbw_next;
            fbh_reg       <= fbh_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        dsr_reg       <= dsr_next;
        phase_reg     <= phase_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        ndcx_reg      <= ndcx_next;
        ndcy_reg      <= ndcy_next;
        stat_reg      <= stat_next;
        out_phase_reg <= out_phase_next;
        out_ox_reg    <= out_ox_next;
        out_oy_reg    <= out_oy_next;
        out_ndcx_reg  <= out_ndcx_next;
        out_ndcy_reg  <= out_ndcy_next;
        out_stat_reg  <= out_stat_next;
    end

    assign out_valid = out_valid_reg;
    assign phase     = out_phase_reg;
    assign offset_x  = out_ox_reg;
    assign offset_y  = out_oy_reg;
    assign ndc_x     = out_ndcx_reg;
    assign ndc_y     = out_ndcy_reg;
    assign status    = out_stat_reg;

    // A sample request starts the modulo or goes straight to the result
    a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (func == FUNC_SAMPLE)) |=> (state_reg == S_MOD || state_reg == S_DONE))
        else $error("sample request did not start the sequencer");

    // The divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD || state_reg == S_NDCX || state_reg == S_NDCY)
        |-> (dsr_reg != '0))
        else $error("divider running with zero divisor");

    // A good result carries a phase within the cycle
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg == ST_OK) |-> (phase != '0 && phase <= PC_MAX))
        else $error("result phase out of range");

    // Frame zero gives an empty result
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg == ST_FRAME_ZERO)
        |-> (phase == '0 && ndc_x == '0 && ndc_y == '0))
        else $error("frame zero result not cleared");

endmodule

FILE: tb/tb_halton_jitter_sample_generator.sv
`timescale 1ns / 1ps

module tb_halton_jitter_sample_generator;
    import hjsg_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RST_CYCLES    = 6;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_MAX     = 64;
    localparam int DIM_MAX       = 16384;

    typedef struct {
        logic                    func;
        logic [FRAME_W-1:0]      frame;
        logic [SLOT_W-1:0]       slot;
        logic signed [TAB_W-1:0] tab_x;
        logic signed [TAB_W-1:0] tab_y;
    } jitter_req_t;

    typedef struct {
        logic [PHASE_W-1:0]      phase;
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic signed [NDC_W-1:0] ndc_x;
        logic signed [NDC_W-1:0] ndc_y;
        status_t                 status;
    } jitter_res_t;

    // DUT ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    func = FUNC_LOAD;
    logic [FRAME_W-1:0]      frame_number = '0;
    logic [SLOT_W-1:0]       table_slot = '0;
    logic signed [TAB_W-1:0] table_x = '0;
    logic signed [TAB_W-1:0] table_y = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [PHASE_W-1:0]      phase;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic signed [NDC_W-1:0] ndc_x;
    logic signed [NDC_W-1:0] ndc_y;
    logic [1:0]              status;

    // Request and result bookkeeping
    jitter_req_t pending_reqs[$];
    jitter_res_t expected_jitter[$];
    jitter_req_t next_req;
    logic        req_taken = 1'b0;
    logic        slot_loaded[TAB_DEPTH] = '{default: 1'b0};
    int          random_issued = 0;
    int          err_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Idle control
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    // Predicted block state
    logic                    cur_mode = 1'b0;
    logic [PHASE_W-1:0]      cur_phases = 7'd8;
    logic [CFG_W-1:0]        cur_width = 15'd1920;
    logic [CFG_W-1:0]        cur_height = 15'd1080;
    logic signed [TAB_W-1:0] offset_tab_x[TAB_DEPTH];
    logic signed [TAB_W-1:0] offset_tab_y[TAB_DEPTH];

    halton_jitter_sample_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .frame_number (frame_number),
        .table_slot   (table_slot),
        .table_x      (table_x),
        .table_y      (table_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phase        (phase),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .ndc_x        (ndc_x),
        .ndc_y        (ndc_y),
        .status       (status)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Phase count register as the block uses it: 0 acts as 1, clamp at the max
    function automatic int fold_phases(logic [PHASE_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > PHASE_MAX)
            return PHASE_MAX;
        return int'(raw);
    endfunction

    // Base-2 radical inverse of 7 bits, Q0.16 centered
    function automatic longint halton2_off(int p);
        logic [6:0] rev;
        for (int i = 0; i < 7; i++)
            rev[6-i] = p[i];
        return longint'(rev) * 512 - 32768;
    endfunction

    // Base-3 radical inverse of 4 digits, rounded down
    function automatic longint halton3_off(int p);
        longint n;
        int     q;
        n = 0;
        q = p;
        for (int i = 0; i < 4; i++)
        begin
            n = n * 3 + q % 3;
            q = q / 3;
        end
        return (n * 65536) / 81 - 32768;
    endfunction

    // 2*off/dim in Q.32, truncated toward zero
    function automatic logic signed [NDC_W-1:0] ndc_scale(longint off, longint dim);
        longint q;
        q = (off * 131072) / dim;
        return q[NDC_W-1:0];
    endfunction

    // Load updates the table; sample queues one expected result
    task automatic predict_jitter(input jitter_req_t r);
        jitter_res_t       res;
        longint unsigned   pc;
        longint unsigned   ph;
        longint unsigned   w;
        longint unsigned   h;
        longint            ox;
        longint            oy;
        int                idx;
        if (r.func == FUNC_LOAD)
        begin
            offset_tab_x[r.slot] = r.tab_x;
            offset_tab_y[r.slot] = r.tab_y;
            return;
        end
        res.phase  = '0;
        res.off_x  = '0;
        res.off_y  = '0;
        res.ndc_x  = '0;
        res.ndc_y  = '0;
        res.status = ST_OK;
        if (r.frame == 0)
        begin
            res.status = ST_FRAME_ZERO;
            expected_jitter.push_back(res);
            return;
        end
        pc = fold_phases(cur_phases);
        ph = ((r.frame - 1) % pc) + 1;
        res.phase = ph[PHASE_W-1:0];
        w = (cur_width > DIM_MAX) ? DIM_MAX : cur_width;
        h = (cur_height > DIM_MAX) ? DIM_MAX : cur_height;
        if (w == 0 || h == 0)
        begin
            res.status = ST_ZERO_DIM;
            expected_jitter.push_back(res);
            return;
        end
        if (cur_mode)
        begin
            idx = int'(ph) - 1;
            ox = offset_tab_x[idx];
            oy = offset_tab_y[idx];
        end
        else
        begin
            ox = halton2_off(int'(ph));
            oy = halton3_off(int'(ph));
        end
        if (ox < -32768 || ox > 32767 || oy < -32768 || oy > 32767)
        begin
            res.status = ST_TABLE_RANGE;
            expected_jitter.push_back(res);
            return;
        end
        res.off_x = ox[OFF_W-1:0];
        res.off_y = oy[OFF_W-1:0];
        res.ndc_x = ndc_scale(ox, longint'(w));
        res.ndc_y = ndc_scale(oy, longint'(h));
        expected_jitter.push_back(res);
    endtask

    task automatic check_jitter();
        jitter_res_t exp_r;
        if (expected_jitter.size() == 0)
        begin
            $error("unexpected result: phase %0d status %0d", phase, status);
            err_cnt++;
            return;
        end
        exp_r = expected_jitter.pop_front();
        if (phase !== exp_r.phase)
        begin
            $error("phase: expected %0d, got %0d", exp_r.phase, phase);
            err_cnt++;
        end
        if (offset_x !== exp_r.off_x)
        begin
            $error("offset_x: expected %0d, got %0d", exp_r.off_x, offset_x);
            err_cnt++;
        end
        if (offset_y !== exp_r.off_y)
        begin
            $error("offset_y: expected %0d, got %0d", exp_r.off_y, offset_y);
            err_cnt++;
        end
        if (ndc_x !== exp_r.ndc_x)
        begin
            $error("ndc_x: expected %0d, got %0d", exp_r.ndc_x, ndc_x);
            err_cnt++;
        end
        if (ndc_y !== exp_r.ndc_y)
        begin
            $error("ndc_y: expected %0d, got %0d", exp_r.ndc_y, ndc_y);
            err_cnt++;
        end
        if (status !== exp_r.status)
        begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            err_cnt++;
        end
    endtask

    // Request builders
    task automatic push_sample(input logic [FRAME_W-1:0] f);
        jitter_req_t r;
        r.func  = FUNC_SAMPLE;
        r.frame = f;
        r.slot  = SLOT_W'($urandom);
        r.tab_x = TAB_W'($urandom);
        r.tab_y = TAB_W'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic push_load(input int slot, input int x, input int y);
        jitter_req_t r;
        r.func  = FUNC_LOAD;
        r.frame = {$urandom, $urandom};
        r.slot  = slot[SLOT_W-1:0];
        r.tab_x = x[TAB_W-1:0];
        r.tab_y = y[TAB_W-1:0];
        slot_loaded[slot] = 1'b1;
        pending_reqs.push_back(r);
    endtask

    // Mostly in-range offsets, some across the whole 18-bit field
    function automatic logic signed [TAB_W-1:0] rand_offset();
        int v;
        if ($urandom_range(4) == 0)
            v = $urandom;
        else
            v = int'($urandom_range(65535)) - 32768;
        return v[TAB_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        int                 r;
        logic [FRAME_W-1:0] f;
        r = $urandom_range(99);
        if (r < 3)
            f = '0;
        else if (r < 45)
            f = FRAME_W'($urandom_range(300, 1));
        else if (r < 52)
            f = '1 - FRAME_W'($urandom_range(200));
        else
            f = {$urandom, $urandom};
        return f;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(19))
            0: return 0;
            1: return DIM_MAX;
            2: return $urandom_range(32767, DIM_MAX + 1);
            3: return 1;
            4: return $urandom_range(64, 1);
            default: return $urandom_range(DIM_MAX, 1);
        endcase
    endfunction

    function automatic int pick_phase_count();
        case ($urandom_range(9))
            0: return 0;
            1: return PHASE_MAX;
            2: return $urandom_range(127, PHASE_MAX + 1);
            3, 4, 5: return $urandom_range(8, 1);
            default: return $urandom_range(PHASE_MAX, 1);
        endcase
    endfunction

    // Register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic [CFG_W-1:0] data;
        data = val[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_MODE: cur_mode   = data[0];
            CFG_PHASE_COUNT:  cur_phases = data[PHASE_W-1:0];
            CFG_FB_WIDTH:     cur_width  = data;
            CFG_FB_HEIGHT:    cur_height = data;
            default: ;
        endcase
    endtask

    // Every request taken, every result back, then let loads settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid);
        while (expected_jitter.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Table mode must never read a slot that was never loaded
    task automatic cover_table(input int pc);
        for (int i = 0; i < pc; i++)
            if (!slot_loaded[i])
                push_load(i, rand_offset(), rand_offset());
    endtask

    task automatic random_segment();
        int mode;
        int pcr;
        int n;
        mode = $urandom_range(1);
        pcr  = pick_phase_count();
        wait_idle();
        write_reg(CFG_PATTERN_MODE, mode);
        write_reg(CFG_PHASE_COUNT, pcr);
        write_reg(CFG_FB_WIDTH, pick_dim());
        write_reg(CFG_FB_HEIGHT, pick_dim());
        if (mode != 0)
            cover_table(fold_phases(pcr[PHASE_W-1:0]));
        n = $urandom_range(30, 12);
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
                push_load($urandom_range(TAB_DEPTH - 1), rand_offset(), rand_offset());
            else
                push_sample(rand_frame());
            random_issued++;
        end
    endtask

    // Request driver: new payload only after the previous one was taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                in_valid     <= 1'b1;
                func         <= next_req.func;
                frame_number <= next_req.frame;
                table_slot   <= next_req.slot;
                table_x      <= next_req.tab_x;
                table_y      <= next_req.tab_y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Accepted requests feed the predictor
    always @(posedge clk)
    begin
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
        begin
            next_req.func  = func;
            next_req.frame = frame_number;
            next_req.slot  = table_slot;
            next_req.tab_x = table_x;
            next_req.tab_y = table_y;
            predict_jitter(next_req);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_jitter();
    end

    // Receiver stall: random, or forced during a long hold
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    // Long receiver hold, counted here
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_served != hold_asked)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 31;
        recv_idle_pct = 49;

        // Reset settings: frame zero, wrap of 8 phases, largest frame
        push_sample(64'd0);
        push_sample(64'd1);
        push_sample(64'd2);
        push_sample(64'd8);
        push_sample(64'd9);
        push_sample('1);

        // Phase count of 64 on a 1x1 target, largest NDC magnitude
        wait_idle();
        write_reg(CFG_PATTERN_MODE, 0);
        write_reg(CFG_PHASE_COUNT, 64);
        write_reg(CFG_FB_WIDTH, 1);
        write_reg(CFG_FB_HEIGHT, 1);
        push_sample(64'd64);
        push_sample(64'd63);
        push_sample(64'd32);
        push_sample(64'd128);

        // Phase count zero acts as one; zero width; frame zero wins over it
        wait_idle();
        write_reg(CFG_PHASE_COUNT, 0);
        write_reg(CFG_FB_WIDTH, 0);
        push_sample(64'd5);
        push_sample(64'd0);

        // Oversized phase count and width are clamped
        wait_idle();
        write_reg(CFG_PHASE_COUNT, 127);
        write_reg(CFG_FB_WIDTH, 32767);
        write_reg(CFG_FB_HEIGHT, DIM_MAX);
        push_sample(64'd100);
        push_sample(64'd65);

        // Table entries at and beyond the valid range
        wait_idle();
        push_load(0, -32768, 32767);
        push_load(1, 32768, 0);
        push_load(2, 0, -32769);
        push_load(3, -131072, 131071);
        push_load(63, 131071, -131072);

        wait_idle();
        write_reg(CFG_PATTERN_MODE, 1);
        write_reg(CFG_PHASE_COUNT, 4);
        write_reg(CFG_FB_WIDTH, 1);
        write_reg(CFG_FB_HEIGHT, 1);
        push_sample(64'd1);
        push_sample(64'd2);
        push_sample(64'd3);
        push_sample(64'd4);
        push_sample(64'd5);

        // Zero width is reported ahead of a bad table entry
        wait_idle();
        write_reg(CFG_FB_WIDTH, 0);
        push_sample(64'd2);

        // Random part, three idle profiles
        while (random_issued < RANDOM_ITEMS)
        begin
            if (random_issued < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 49;
            end
            else if (random_issued < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_segment();
        end

        // Back-pressure: receiver holds off while requests keep coming
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_PATTERN_MODE, 0);
        write_reg(CFG_PHASE_COUNT, 64);
        write_reg(CFG_FB_WIDTH, 1920);
        write_reg(CFG_FB_HEIGHT, 1080);
        hold_asked = hold_asked + 1;
        repeat (10) push_sample(FRAME_W'($urandom_range(1000, 1)));

        wait_idle();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
